### hw/rtl/bmffs_pkg.sv
// Shared types, constants and helper functions of the bitmap store with find-first-set.
package bmffs_pkg;

    localparam int MAP_WORDS = 32;
    localparam int WORD_BITS = 32;
    localparam int WORD_AW = 5;
    localparam int POS_W = 10;
    localparam int ACTIVE_W = 6;
    localparam int ACTIVE_RESET = 32;
    localparam int LIMIT_MAX = 32;

    typedef enum logic [2:0] {
        KIND_GET     = 3'd0,
        KIND_SET     = 3'd1,
        KIND_CLR     = 3'd2,
        KIND_COPY    = 3'd3,
        KIND_FFS     = 3'd4,
        KIND_CLR_ALL = 3'd5
    } kind_t;

    typedef struct packed {
        logic req_load;
        logic rd_src;
        logic rd_dst;
        logic wr_src;
        logic wr_dst;
        logic cap_src;
        logic cap_get;
        logic clr_all;
        logic scan_run;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       scan_done;
        logic       out_busy;
    } status_t;

    function automatic logic word_ok(input logic [WORD_AW-1:0] w);
        return {1'b0, w} < ACTIVE_W'(MAP_WORDS);
    endfunction

    function automatic logic [WORD_AW-1:0] low_set_pos(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] iso;
        logic [WORD_AW-1:0]   idx;
        iso = v & (~v + WORD_BITS'(1));
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (iso[i])
            begin
                idx = idx | WORD_AW'(i);
            end
        end
        return idx;
    endfunction

endpackage

### hw/rtl/bmffs_req_if.sv
// Request channel interface carrying one bitmap operation per transaction.
interface bmffs_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [9:0] bit_index;
    logic [9:0] copy_to_index;
    logic [9:0] search_start;

    modport source (output valid, kind, bit_index, copy_to_index, search_start, input ready);
    modport sink (input valid, kind, bit_index, copy_to_index, search_start, output ready);
endinterface

### hw/rtl/bmffs_rsp_if.sv
// Response channel interface carrying one result per transaction.
interface bmffs_rsp_if;
    logic       valid;
    logic       ready;
    logic       bit_value;
    logic       found;
    logic [9:0] found_index;

    modport source (output valid, bit_value, found, found_index, input ready);
    modport sink (input valid, bit_value, found, found_index, output ready);
endinterface

### hw/rtl/bmffs_cfg_if.sv
// Configuration write channel interface carrying the active word count.
interface bmffs_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### hw/rtl/bitmap_store_find_first_set_core.sv
// Top level of the bitmap store with find-first-set, joining controller and datapath.
//
// The block keeps a 1024-bit map as 32 words of 32 bits in a RAM. Each request
// transaction on req carries one operation: get, set, clear, copy, find first
// set, or clear all. Every request yields exactly one response transaction on rsp
// with bit_value, found and found_index; unused fields are zero.
// The cfg channel writes the active word count that bounds the search. It is
// always ready and should be written only while no request is in flight.
// A request is taken when the controller is idle. After dispatch, clear all and the
// unused kinds go straight to loading the response; get reads the word and captures
// the bit, set and clear read the word and write it back, and copy reads the source
// word, then reads and writes the destination word. Find first set reads one word per
// cycle through the RAM read port, up to the active word count, then loads its result.
// The next request is taken in the cycle after the response is loaded.
// Reset clears a per-word valid bit, so the map reads as all zeros at once; no
// clearing pass is needed, and the active word count returns to 32.
// The response sits in an output register. If the receiver stalls, the next
// request is still accepted and processed, and the block holds its own result
// until that register is free.
module bitmap_store_find_first_set_core (
    input logic         clk,
    input logic         rst_n,
    bmffs_cfg_if.sink   cfg,
    bmffs_req_if.sink   req,
    bmffs_rsp_if.source rsp
);

    bmffs_pkg::cmd_t    cmd;
    bmffs_pkg::status_t status;
    logic               in_ready;

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    bmffs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bmffs_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_kind          (req.kind),
        .in_bit_index     (req.bit_index),
        .in_copy_to_index (req.copy_to_index),
        .in_search_start  (req.search_start),
        .cfg_we           (cfg.valid),
        .cfg_data         (cfg.data),
        .out_ready        (rsp.ready),
        .out_valid        (rsp.valid),
        .out_bit_value    (rsp.bit_value),
        .out_found        (rsp.found),
        .out_found_index  (rsp.found_index)
    );

endmodule

### hw/rtl/bmffs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bmffs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/bmffs_ctrl.sv
// Controller state machine that sequences each bitmap operation.
module bmffs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bmffs_pkg::status_t status,
    output bmffs_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_GET_EVAL,
        S_BIT_WR,
        S_COPY_RD,
        S_COPY_WR,
        S_SEARCH,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.kind)
                    bmffs_pkg::KIND_GET:
                    begin
                        cmd.rd_src = 1'b1;
                        state_next = S_GET_EVAL;
                    end
                    bmffs_pkg::KIND_SET, bmffs_pkg::KIND_CLR:
                    begin
                        cmd.rd_src = 1'b1;
                        state_next = S_BIT_WR;
                    end
                    bmffs_pkg::KIND_COPY:
                    begin
                        cmd.rd_src = 1'b1;
                        state_next = S_COPY_RD;
                    end
                    bmffs_pkg::KIND_FFS:
                    begin
                        state_next = S_SEARCH;
                    end
                    bmffs_pkg::KIND_CLR_ALL:
                    begin
                        cmd.clr_all = 1'b1;
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_GET_EVAL:
            begin
                cmd.cap_get = 1'b1;
                state_next = S_FINISH;
            end
            S_BIT_WR:
            begin
                cmd.wr_src = 1'b1;
                state_next = S_FINISH;
            end
            S_COPY_RD:
            begin
                cmd.cap_src = 1'b1;
                cmd.rd_dst = 1'b1;
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                cmd.wr_dst = 1'b1;
                state_next = S_FINISH;
            end
            S_SEARCH:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/bmffs_dp.sv
// Datapath holding the bitmap memory, request registers, search pointer and result register.
module bmffs_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  bmffs_pkg::cmd_t    cmd,
    output bmffs_pkg::status_t status,
    input  logic [2:0]         in_kind,
    input  logic [9:0]         in_bit_index,
    input  logic [9:0]         in_copy_to_index,
    input  logic [9:0]         in_search_start,
    input  logic               cfg_we,
    input  logic [5:0]         cfg_data,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               out_bit_value,
    output logic               out_found,
    output logic [9:0]         out_found_index
);

    localparam int AW = bmffs_pkg::WORD_AW;
    localparam int WB = bmffs_pkg::WORD_BITS;
    localparam int NW = bmffs_pkg::MAP_WORDS;
    localparam int CW = bmffs_pkg::ACTIVE_W;

    logic [2:0]    kind_reg;
    logic [9:0]    bit_reg;
    logic [9:0]    to_reg;
    logic [9:0]    start_reg;
    logic [CW-1:0] w_reg;
    logic [AW-1:0] ev_reg;
    logic          pend_reg;
    logic          first_reg;
    logic          ev_first_reg;
    logic          src_bit_reg;
    logic          rv_reg;
    logic          res_bit_reg;
    logic          res_found_reg;
    logic [9:0]    res_idx_reg;
    logic [NW-1:0] valid_reg;
    logic [CW-1:0] active_reg;
    logic          out_valid_reg;
    logic          out_bit_reg;
    logic          out_found_reg;
    logic [9:0]    out_idx_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WB-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [WB-1:0] ram_rdata;

    logic [WB-1:0] rd_word;
    logic [WB-1:0] scan_word;
    logic [CW-1:0] limit;
    logic          scan_hit;
    logic          scan_exhausted;
    logic          scan_issue;
    logic          src_bit;

    logic [AW-1:0] src_word;
    logic [AW-1:0] dst_word;

    assign src_word = bit_reg[9:5];
    assign dst_word = to_reg[9:5];

    assign rd_word = rv_reg ? ram_rdata : '0;
    assign src_bit = bmffs_pkg::word_ok(src_word) ? rd_word[bit_reg[4:0]] : 1'b0;

    assign limit = (active_reg > CW'(bmffs_pkg::LIMIT_MAX)) ? CW'(bmffs_pkg::LIMIT_MAX)
                                                             : active_reg;
    assign scan_word = ev_first_reg ? (rd_word & ({WB{1'b1}} << start_reg[4:0])) : rd_word;
    assign scan_hit = pend_reg && (scan_word != '0);
    assign scan_exhausted = !scan_hit && (w_reg >= limit);
    assign scan_issue = cmd.scan_run && !scan_hit && !scan_exhausted;

    assign status.kind = kind_reg;
    assign status.scan_done = scan_hit || scan_exhausted;
    assign status.out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        ram_re = cmd.rd_src || cmd.rd_dst || scan_issue;
        if (cmd.rd_dst)
        begin
            ram_raddr = dst_word;
        end
        else if (scan_issue)
        begin
            ram_raddr = w_reg[AW-1:0];
        end
        else
        begin
            ram_raddr = src_word;
        end

        ram_we = 1'b0;
        ram_waddr = src_word;
        ram_wdata = rd_word;
        if (cmd.wr_src)
        begin
            ram_we = bmffs_pkg::word_ok(src_word);
            ram_wdata[bit_reg[4:0]] = (kind_reg == bmffs_pkg::KIND_SET);
        end
        else if (cmd.wr_dst)
        begin
            ram_we = bmffs_pkg::word_ok(dst_word);
            ram_waddr = dst_word;
            ram_wdata[to_reg[4:0]] = src_bit_reg;
        end
    end

    bmffs_ram #(
        .WIDTH (WB),
        .DEPTH (NW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            active_reg <= CW'(bmffs_pkg::ACTIVE_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_data;
            end
            if (cmd.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            rv_reg <= valid_reg[ram_raddr];
        end
        if (cmd.req_load)
        begin
            kind_reg <= in_kind;
            bit_reg <= in_bit_index;
            to_reg <= in_copy_to_index;
            start_reg <= in_search_start;
            w_reg <= {1'b0, in_search_start[9:5]};
            pend_reg <= 1'b0;
            first_reg <= 1'b1;
            res_bit_reg <= 1'b0;
            res_found_reg <= 1'b0;
            res_idx_reg <= '0;
        end
        if (cmd.cap_src)
        begin
            src_bit_reg <= src_bit;
        end
        if (cmd.cap_get)
        begin
            res_bit_reg <= src_bit;
        end
        if (cmd.scan_run)
        begin
            if (scan_hit)
            begin
                res_found_reg <= 1'b1;
                res_idx_reg <= {ev_reg, bmffs_pkg::low_set_pos(scan_word)};
            end
            else if (scan_issue)
            begin
                ev_reg <= w_reg[AW-1:0];
                ev_first_reg <= first_reg;
                pend_reg <= 1'b1;
                first_reg <= 1'b0;
                w_reg <= w_reg + CW'(1);
            end
        end
        if (cmd.out_load)
        begin
            out_bit_reg <= res_bit_reg;
            out_found_reg <= res_found_reg;
            out_idx_reg <= res_idx_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_bit_value = out_bit_reg;
    assign out_found = out_found_reg;
    assign out_found_index = out_idx_reg;

    a_clear_all_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_all |=> (valid_reg == '0))
        else $error("valid bits not cleared after clear all");

    a_scan_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_issue |-> (w_reg < limit))
        else $error("search read beyond active words");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("result register overwritten while stalled");

    a_found_only_ffs: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && res_found_reg) |-> (kind_reg == bmffs_pkg::KIND_FFS))
        else $error("found flag set for an operation other than search");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("bitmap read and write in the same cycle");

endmodule
